[hdl/clnw_pkg.sv]
// shared types, constants and tables of the character display nibble writer
package clnw_pkg;

    // field and register widths
    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int MS_W        = 8;
    localparam int POS_W       = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int STEP_W      = 3;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // register reset values
    localparam logic [MS_W-1:0]   PULSE_RESET     = 8'd15;
    localparam logic [POS_W-1:0]  LINE_LEN_RESET  = 6'd16;
    localparam logic [BYTE_W-1:0] WRAP_CMD_RESET  = 8'hC0;
    localparam logic [MS_W-1:0]   WRAP_WAIT_RESET = 8'd10;

    // init timing and position limit
    localparam logic [MS_W-1:0]  INIT_FIRST_WAIT  = 8'd30;
    localparam logic [MS_W-1:0]  INIT_SECOND_WAIT = 8'd10;
    localparam logic [POS_W-1:0] POS_MAX          = 6'd63;

    // last step of each kind of job, and the step of the second init byte
    localparam logic [STEP_W-1:0] STEP_LAST_INIT = 3'd7;
    localparam logic [STEP_W-1:0] STEP_LAST_BYTE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LAST_WRAP = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SECOND_INIT_BYTE = 3'd2;

    // input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 2'd0,
        CMD_CMD    = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_STRING = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE_PULSE = 2'd0,
        CFG_LINE_LENGTH  = 2'd1,
        CFG_WRAP_COMMAND = 2'd2,
        CFG_WRAP_WAIT    = 2'd3
    } cfg_index_t;

    // kinds of job handed from front to back
    typedef enum logic [1:0] {
        JOB_INIT      = 2'd0,
        JOB_BYTE      = 2'd1,
        JOB_BYTE_WRAP = 2'd2
    } job_kind_t;

    // one classified word waiting for the back
    typedef struct packed {
        job_kind_t         kind;
        logic              rs;
        logic [BYTE_W-1:0] value;
        logic [MS_W-1:0]   first_wait;
    } job_t;

    // init byte sequence
    function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h33;
            2'd1:    b = 8'h32;
            2'd2:    b = 8'h0C;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    // saturating add of two millisecond counts
    function automatic logic [MS_W-1:0] add_sat(input logic [MS_W-1:0] a,
                                                 input logic [MS_W-1:0] b);
        logic [MS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
    endfunction

endpackage

[hdl/clnw_front.sv]
// front: accepts input words, tracks string position and classifies into jobs
module clnw_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [clnw_pkg::CMD_W-1:0]       cmd,
    input  logic [clnw_pkg::BYTE_W-1:0]      byte_value,
    input  logic                             first_of_string,
    input  logic [clnw_pkg::POS_W-1:0]       line_length,
    input  logic [clnw_pkg::MS_W-1:0]        wrap_wait_ms,
    output clnw_pkg::job_t                   job
);
    import clnw_pkg::*;

    logic [POS_W-1:0] position_reg, position_next;
    logic             pending_reg, pending_next;
    logic [POS_W-1:0] pos;
    logic [MS_W-1:0]  extra;
    logic             wrap;

    // position of this character and wrap decision
    assign pos   = first_of_string ? '0 : position_reg;
    assign wrap  = ({1'b0, pos} + 7'd1) == {1'b0, line_length};
    assign extra = pending_reg ? wrap_wait_ms : '0;

    // classify the word
    always_comb
    begin
        job.rs         = 1'b0;
        job.value      = byte_value;
        job.kind       = JOB_BYTE;
        job.first_wait = extra;
        position_next  = position_reg;
        pending_next   = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_INIT:
            begin
                job.kind       = JOB_INIT;
                job.first_wait = add_sat(INIT_FIRST_WAIT, extra);
            end
            CMD_CMD:
            begin
                job.rs = 1'b0;
            end
            CMD_DATA:
            begin
                job.rs = 1'b1;
            end
            CMD_STRING:
            begin
                job.rs        = 1'b1;
                job.kind      = wrap ? JOB_BYTE_WRAP : JOB_BYTE;
                pending_next  = wrap;
                position_next = (pos < POS_MAX) ? pos + 6'd1 : pos;
            end
        endcase
    end

    // string state, updated on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            pending_reg  <= 1'b0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

[hdl/clnw_queue.sv]
// short queue of classified jobs between front and back
module clnw_queue #(
    parameter int DEPTH = clnw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  clnw_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output clnw_pkg::job_t head_job
);
    import clnw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // no overflow or underflow
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

[hdl/clnw_back.sv]
// back: expands each job into nibble transfers behind an output register
module clnw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  clnw_pkg::job_t                head_job,
    output logic                          pop,
    input  logic [clnw_pkg::MS_W-1:0]     enable_pulse_ms,
    input  logic [clnw_pkg::BYTE_W-1:0]   wrap_command,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          register_select,
    output logic [clnw_pkg::NIBBLE_W-1:0] nibble,
    output logic [clnw_pkg::MS_W-1:0]     pulse_ms,
    output logic [clnw_pkg::MS_W-1:0]     wait_before_ms,
    output logic                          last
);
    import clnw_pkg::*;

    logic [STEP_W-1:0]   step_reg;
    logic                valid_reg;
    logic                rs_reg, last_reg;
    logic [NIBBLE_W-1:0] nibble_reg;
    logic [MS_W-1:0]     pulse_reg, wait_reg;

    logic                load;
    logic                t_rs, t_last;
    logic [BYTE_W-1:0]   t_byte;
    logic [MS_W-1:0]     t_wait;
    logic [NIBBLE_W-1:0] t_nibble;

    assign load = head_valid && (!valid_reg || !out_stall);
    assign pop  = load && t_last;

    // transfer for the current step of the head job
    always_comb
    begin
        t_rs   = head_job.rs;
        t_byte = head_job.value;
        t_wait = (step_reg == '0) ? head_job.first_wait : '0;
        t_last = 1'b0;
        unique case (head_job.kind)
            JOB_INIT:
            begin
                t_rs   = 1'b0;
                t_byte = init_byte(step_reg[2:1]);
                if (step_reg == STEP_SECOND_INIT_BYTE)
                begin
                    t_wait = INIT_SECOND_WAIT;
                end
                t_last = (step_reg == STEP_LAST_INIT);
            end
            JOB_BYTE:
            begin
                t_last = (step_reg == STEP_LAST_BYTE);
            end
            JOB_BYTE_WRAP:
            begin
                if (step_reg[1])
                begin
                    t_rs   = 1'b0;
                    t_byte = wrap_command;
                end
                t_last = (step_reg == STEP_LAST_WRAP);
            end
            default:
            begin
                t_last = 1'b1;
            end
        endcase
        t_nibble = step_reg[0] ? t_byte[3:0] : t_byte[7:4];
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= t_last ? '0 : step_reg + 1'b1;
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rs_reg     <= t_rs;
            nibble_reg <= t_nibble;
            pulse_reg  <= enable_pulse_ms;
            wait_reg   <= t_wait;
            last_reg   <= t_last;
        end
    end

    assign out_valid       = valid_reg;
    assign register_select = rs_reg;
    assign nibble          = nibble_reg;
    assign pulse_ms        = pulse_reg;
    assign wait_before_ms  = wait_reg;
    assign last            = last_reg;

    // a job in progress stays at the head of the queue
    a_step_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> head_valid)
        else $error("step counter running without a job");
    a_byte_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_job.kind == JOB_BYTE) |-> (step_reg <= STEP_LAST_BYTE))
        else $error("byte job beyond its last step");
    a_wrap_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_job.kind == JOB_BYTE_WRAP) |-> (step_reg <= STEP_LAST_WRAP))
        else $error("wrap job beyond its last step");

endmodule

[hdl/char_lcd_nibble_writer_unit.sv]
// top level of the character display nibble writer: config, front, queue, back
// with the queue empty, an accepted word is first written into the queue, then its first
// transfer is loaded into the back's output register
// throughput: one nibble transfer per cycle while out_stall is low; a word gives 2, 4 or 8
// transfers (byte, string character with wrap, init) through the back's single transfer register
// the front takes a word every cycle while the queue has room
// reset: config registers to defaults, string position and wrap flag cleared, queue empty
module char_lcd_nibble_writer_unit #(
    parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [clnw_pkg::CMD_W-1:0]        cmd,
    input  logic [clnw_pkg::BYTE_W-1:0]       byte_value,
    input  logic                              first_of_string,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              register_select,
    output logic [clnw_pkg::NIBBLE_W-1:0]     nibble,
    output logic [clnw_pkg::MS_W-1:0]         pulse_ms,
    output logic [clnw_pkg::MS_W-1:0]         wait_before_ms,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [clnw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clnw_pkg::*;

    logic [MS_W-1:0]   pulse_cfg_reg;
    logic [POS_W-1:0]  line_len_cfg_reg;
    logic [BYTE_W-1:0] wrap_cmd_cfg_reg;
    logic [MS_W-1:0]   wrap_wait_cfg_reg;

    logic accept, q_full, q_head_valid, q_pop;
    job_t front_job, head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_cfg_reg     <= PULSE_RESET;
            line_len_cfg_reg  <= LINE_LEN_RESET;
            wrap_cmd_cfg_reg  <= WRAP_CMD_RESET;
            wrap_wait_cfg_reg <= WRAP_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE_PULSE: pulse_cfg_reg     <= cfg_data;
                CFG_LINE_LENGTH:  line_len_cfg_reg  <= cfg_data[POS_W-1:0];
                CFG_WRAP_COMMAND: wrap_cmd_cfg_reg  <= cfg_data;
                CFG_WRAP_WAIT:    wrap_wait_cfg_reg <= cfg_data;
            endcase
        end
    end

    // input handshake
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    clnw_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .cmd             (cmd),
        .byte_value      (byte_value),
        .first_of_string (first_of_string),
        .line_length     (line_len_cfg_reg),
        .wrap_wait_ms    (wrap_wait_cfg_reg),
        .job             (front_job)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (front_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (head_job)
    );

    clnw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_job        (head_job),
        .pop             (q_pop),
        .enable_pulse_ms (pulse_cfg_reg),
        .wrap_command    (wrap_cmd_cfg_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .register_select (register_select),
        .nibble          (nibble),
        .pulse_ms        (pulse_ms),
        .wait_before_ms  (wait_before_ms),
        .last            (last)
    );

endmodule

[tb/sv/tb_char_lcd_nibble_writer_unit.sv]
// self-checking testbench of the character display nibble writer
`timescale 1ns / 1ps

module tb_char_lcd_nibble_writer_unit;
    import clnw_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;
    localparam logic [31:0] INIT_SEQUENCE = 32'h33320C01;

    // one input word as driven on the ports
    typedef struct packed {
        cmd_t              op;
        logic [BYTE_W-1:0] value;
        logic              first;
    } word_t;

    // one nibble transfer as seen on the result side
    typedef struct packed {
        logic                rs;
        logic [NIBBLE_W-1:0] nib;
        logic [MS_W-1:0]     pulse;
        logic [MS_W-1:0]     wait_ms;
        logic                last;
    } transfer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    cmd_t                   cmd = CMD_INIT;
    logic [BYTE_W-1:0]      byte_value = '0;
    logic                   first_of_string = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   register_select;
    logic [NIBBLE_W-1:0]    nibble;
    logic [MS_W-1:0]        pulse_ms;
    logic [MS_W-1:0]        wait_before_ms;
    logic                   last;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_index = CFG_ENABLE_PULSE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // words waiting to be driven and transfers still owed by the block
    word_t      words_to_send[$];
    transfer_t  owed_transfers[$];
    word_t      next_word;
    transfer_t  got_transfer;
    transfer_t  want_transfer;

    int words_pushed   = 0;
    int words_accepted = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    logic in_taken = 1'b0;

    // predictor copy of the registers and the string state
    logic [MS_W-1:0]   pulse_cfg;
    logic [POS_W-1:0]  line_cfg;
    logic [BYTE_W-1:0] wrap_cmd_cfg;
    logic [MS_W-1:0]   wrap_wait_cfg;
    logic [POS_W-1:0]  string_pos;
    logic              wrap_owed;

    char_lcd_nibble_writer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .byte_value      (byte_value),
        .first_of_string (first_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .register_select (register_select),
        .nibble          (nibble),
        .pulse_ms        (pulse_ms),
        .wait_before_ms  (wait_before_ms),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // work out the transfers that one accepted word causes
    task automatic predict_transfers(input cmd_t op, input logic [BYTE_W-1:0] value,
                                     input logic first);
        logic [BYTE_W-1:0] bytes_out [4];
        logic              rs_out [4];
        logic [MS_W-1:0]   wait_out [4];
        logic [MS_W-1:0]   extra;
        logic [MS_W:0]     sum;
        logic [POS_W-1:0]  pos;
        transfer_t         t;
        int                nb;
        extra = wrap_owed ? wrap_wait_cfg : '0;
        wrap_owed = 1'b0;
        nb = 0;
        case (op)
            CMD_INIT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    bytes_out[i] = INIT_SEQUENCE[31 - 8 * i -: 8];
                    rs_out[i]    = 1'b0;
                    wait_out[i]  = '0;
                end
                // first wait plus any owed wrap wait, clamped at full scale
                sum = {1'b0, INIT_FIRST_WAIT} + {1'b0, extra};
                wait_out[0] = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
                wait_out[1] = INIT_SECOND_WAIT;
                nb = 4;
            end
            CMD_CMD, CMD_DATA:
            begin
                bytes_out[0] = value;
                rs_out[0]    = (op == CMD_DATA);
                wait_out[0]  = extra;
                nb = 1;
            end
            default:
            begin
                if (first)
                    string_pos = '0;
                pos = string_pos;
                bytes_out[0] = value;
                rs_out[0]    = 1'b1;
                wait_out[0]  = extra;
                nb = 1;
                // compare one bit wider so a saturated position never matches zero length
                if ({1'b0, pos} + 7'd1 == {1'b0, line_cfg})
                begin
                    bytes_out[1] = wrap_cmd_cfg;
                    rs_out[1]    = 1'b0;
                    wait_out[1]  = '0;
                    nb = 2;
                    wrap_owed = 1'b1;
                end
                if (pos < POS_MAX)
                    string_pos = pos + 1'b1;
            end
        endcase
        // high nibble first, last flag on the final transfer
        for (int i = 0; i < nb; i++)
        begin
            t = '{rs_out[i], bytes_out[i][7:4], pulse_cfg, wait_out[i], 1'b0};
            owed_transfers.push_back(t);
            t = '{rs_out[i], bytes_out[i][3:0], pulse_cfg, 8'd0, (i == nb - 1)};
            owed_transfers.push_back(t);
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = words_to_send.pop_front();
                    in_valid        <= 1'b1;
                    cmd             <= next_word.op;
                    byte_value      <= next_word.value;
                    first_of_string <= next_word.first;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                predict_transfers(cmd, byte_value, first_of_string);
                words_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                got_transfer = '{register_select, nibble, pulse_ms, wait_before_ms, last};
                if (owed_transfers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected transfer rs=%0d nibble=%h pulse=%0d",
                                 got_transfer.rs, got_transfer.nib, got_transfer.pulse,
                                 " wait=%0d last=%0d",
                                 got_transfer.wait_ms, got_transfer.last);
                end
                else
                begin
                    want_transfer = owed_transfers.pop_front();
                    if (got_transfer !== want_transfer)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("transfer mismatch: expected rs=%0d nibble=%h",
                                     want_transfer.rs, want_transfer.nib,
                                     " pulse=%0d wait=%0d last=%0d,",
                                     want_transfer.pulse, want_transfer.wait_ms,
                                     want_transfer.last,
                                     " got rs=%0d nibble=%h",
                                     got_transfer.rs, got_transfer.nib,
                                     " pulse=%0d wait=%0d last=%0d",
                                     got_transfer.pulse, got_transfer.wait_ms,
                                     got_transfer.last);
                    end
                end
            end
            // watchdog on cycles where neither side moves a word
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_word(input cmd_t op, input logic [BYTE_W-1:0] value, input logic first);
        word_t w;
        w = '{op, value, first};
        words_to_send.push_back(w);
        words_pushed++;
    endtask

    // wait until every word is taken and every transfer has come back
    task automatic wait_drained();
        while (words_accepted != words_pushed || owed_transfers.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_ENABLE_PULSE: pulse_cfg     = value;
            CFG_LINE_LENGTH:  line_cfg      = value[POS_W-1:0];
            CFG_WRAP_COMMAND: wrap_cmd_cfg  = value;
            default:          wrap_wait_cfg = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] pulse, input logic [7:0] line_len,
                                  input logic [7:0] wrap_cmd, input logic [7:0] wrap_wait);
        write_register(CFG_ENABLE_PULSE, pulse);
        write_register(CFG_LINE_LENGTH, line_len);
        write_register(CFG_WRAP_COMMAND, wrap_cmd);
        write_register(CFG_WRAP_WAIT, wrap_wait);
    endtask

    // mostly well-formed strings with some commands, lone bytes and broken starts
    task automatic queue_random_words(input int count, input int long_len);
        int added;
        int len;
        int len_max;
        int pick;
        for (int k = 0; k < long_len; k++)
            queue_word(CMD_STRING, BYTE_W'($urandom_range(0, 255)), (k == 0));
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                queue_word(CMD_INIT, BYTE_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                added++;
            end
            else if (pick <= 2)
            begin
                queue_word((pick == 1) ? CMD_CMD : CMD_DATA, BYTE_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                len_max = (line_cfg > 6'd40) ? 8 : int'(line_cfg) + 2;
                len = $urandom_range(1, len_max);
                for (int k = 0; k < len; k++)
                    queue_word(CMD_STRING, BYTE_W'($urandom_range(0, 255)),
                               (k == 0) ? ($urandom_range(0, 9) != 0)
                                        : ($urandom_range(0, 19) == 0));
                added += len;
            end
        end
    endtask

    // stimulus and end of run
    initial
    begin
        pulse_cfg     = PULSE_RESET;
        line_cfg      = LINE_LEN_RESET;
        wrap_cmd_cfg  = WRAP_CMD_RESET;
        wrap_wait_cfg = WRAP_WAIT_RESET;
        string_pos    = '0;
        wrap_owed     = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of the registers, every operation, byte extremes
        queue_word(CMD_INIT, 8'hFF, 1'b1);
        queue_word(CMD_CMD, 8'h00, 1'b0);
        queue_word(CMD_DATA, 8'hFF, 1'b1);
        queue_word(CMD_CMD, 8'hFF, 1'b1);
        queue_word(CMD_DATA, 8'h00, 1'b0);
        queue_word(CMD_STRING, 8'h41, 1'b1);
        queue_word(CMD_STRING, 8'h5A, 1'b0);
        wait_drained();

        // zero pulse, short line so the wrap and the owed wait come quickly
        apply_settings(8'd0, 8'd2, 8'hA5, 8'd250);
        queue_word(CMD_STRING, 8'h00, 1'b1);
        queue_word(CMD_STRING, 8'hFF, 1'b0);
        queue_word(CMD_INIT, 8'h00, 1'b0);       // owed wait on init saturates
        queue_word(CMD_STRING, 8'h31, 1'b0);     // past the wrap, no second wrap
        queue_word(CMD_STRING, 8'h41, 1'b1);
        queue_word(CMD_STRING, 8'h42, 1'b0);
        queue_word(CMD_STRING, 8'h43, 1'b0);     // owed wait on a character
        queue_word(CMD_STRING, 8'h44, 1'b1);
        queue_word(CMD_STRING, 8'h45, 1'b0);
        queue_word(CMD_CMD, 8'h80, 1'b1);        // owed wait on a command
        queue_word(CMD_STRING, 8'h46, 1'b1);
        queue_word(CMD_STRING, 8'h47, 1'b0);
        queue_word(CMD_DATA, 8'h7E, 1'b0);       // owed wait on a lone byte
        queue_word(CMD_STRING, 8'h48, 1'b0);
        wait_drained();

        // random phases over register extremes and idling patterns
        send_idle_pct = 0;
        stall_pct     = 0;
        apply_settings(8'd1, 8'd1, 8'h00, 8'd0);
        queue_random_words(10, 0);
        wait_drained();

        send_idle_pct = 49;
        stall_pct     = 0;
        apply_settings(8'd255, 8'd40, 8'hFF, 8'd255);
        queue_random_words(8, 0);
        wait_drained();

        // longest line: wrap at the last counted column, then saturation
        send_idle_pct = 0;
        stall_pct     = 49;
        apply_settings(8'd0, 8'd63, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_words(0, 64);
        wait_drained();

        // zero line length: never wraps, even with the position saturated
        send_idle_pct = 9;
        stall_pct     = 9;
        apply_settings(8'($urandom_range(1, 255)), 8'd0, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        // position still saturated from the long string
        queue_word(CMD_STRING, 8'h61, 1'b0);
        queue_word(CMD_STRING, 8'h62, 1'b0);
        queue_word(CMD_STRING, 8'h63, 1'b0);
        queue_random_words(8, 0);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 0;
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random_words(10, 0);
        wait_drained();

        send_idle_pct = 49;
        stall_pct     = 49;
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(200, 255)));
        queue_random_words(10, 0);
        wait_drained();

        repeat (10) @(negedge clk);
        if (mismatches == 0 && owed_transfers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[char_lcd_nibble_writer_unit.f]
hdl/clnw_pkg.sv
hdl/clnw_front.sv
hdl/clnw_queue.sv
hdl/clnw_back.sv
hdl/char_lcd_nibble_writer_unit.sv
tb/sv/tb_char_lcd_nibble_writer_unit.sv
